/* rtl/core/odo_pkg.sv */
// Shared types, constants and helper functions for the wheel odometry core.
package odo_pkg;

	localparam int unsigned DIV_NUM_W = 61;
	localparam int unsigned DIV_DEN_W = 48;

	localparam logic [29:0] TURN_TO_BAM  = 30'd683565276;
	localparam logic [23:0] INV_GAIN_Q24 = 24'd10188012;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	localparam logic [15:0] LEFT_RADIUS_RST   = 16'd2163;
	localparam logic [15:0] RIGHT_RADIUS_RST  = 16'd2163;
	localparam logic [17:0] TRACK_WIDTH_RST   = 18'd11141;
	localparam logic [15:0] CENTER_OFFSET_RST = 16'd0;

	typedef enum logic [1:0] {
		REG_LEFT_RADIUS   = 2'd0,
		REG_RIGHT_RADIUS  = 2'd1,
		REG_TRACK_WIDTH   = 2'd2,
		REG_CENTER_OFFSET = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic                        start;
		logic signed [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                        done;
		logic signed [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	localparam logic [31:0] ATAN_BAM [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Clamp to plus or minus 2^38.
	function automatic logic signed [39:0] clamp38(input logic signed [63:0] v);
		logic signed [39:0] r;
		if (v > 64'sh40_0000_0000) begin
			r = 40'sh40_0000_0000;
		end else if (v < -64'sh40_0000_0000) begin
			r = -40'sh40_0000_0000;
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/odo_if.sv */
// Ready/valid channel interfaces for wheel samples and pose results.
interface odo_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] left_angle;
	logic [31:0] right_angle;
	logic [47:0] stamp_us;
	modport source (output valid, left_angle, right_angle, stamp_us, input ready);
	modport sink (input valid, left_angle, right_angle, stamp_us, output ready);
endinterface

interface odo_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pose_x;
	logic [31:0] pose_y;
	logic [31:0] heading;
	logic [31:0] linear_speed;
	logic [31:0] turn_rate;
	modport source (output valid, pose_x, pose_y, heading, linear_speed, turn_rate,
		input ready);
	modport sink (input valid, pose_x, pose_y, heading, linear_speed, turn_rate,
		output ready);
endinterface

/* rtl/core/odo_div.sv */
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
module odo_div (
	input  logic                clk,
	input  logic                arst_n,
	input  odo_pkg::div_req_t   req,
	output odo_pkg::div_rsp_t   rsp
);
	localparam int unsigned MW = odo_pkg::DIV_NUM_W - 1;
	localparam int unsigned DW = odo_pkg::DIV_DEN_W;

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic [MW-1:0] acc_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   trial;
	logic          fits;
	logic [MW-1:0] mag;

	assign mag   = req.num[MW] ? MW'(-req.num) : req.num[MW-1:0];
	assign trial = {rem_q[DW-1:0], acc_q[MW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[MW];
			acc_q <= mag;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
			acc_q <= {acc_q[MW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

/* rtl/core/diff_drive_wheel_odometry_core.sv */
// Differential-drive wheel odometry: sequencer, shared multiplier, CORDIC and divider.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  sample   | in  | left_angle, right_angle, stamp_us
//  pose     | out | pose_x, pose_y, heading, linear_speed, turn_rate
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A moving request runs four divisions on the bit-serial divider and the CORDIC
// rotation among the other sequencer steps. A first or non-advancing request
// only updates the stored sample and yields no pose. sample.ready is high only
// while the sequencer is idle; a result waits in the output register and the
// next request is accepted meanwhile. Reset clears the state and pose to zero.
module diff_drive_wheel_odometry_core #(
	parameter int unsigned CORDIC_STEPS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [17:0]      cfg_data,
	odo_in_if.sink           sample,
	odo_out_if.source        pose
);
	localparam int unsigned NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

	typedef enum logic [14:0] {
		S_IDLE     = 15'b000000000000001,
		S_MUL_L    = 15'b000000000000010,
		S_MUL_R    = 15'b000000000000100,
		S_MUL_OFF  = 15'b000000000001000,
		S_DIV_OFF  = 15'b000000000010000,
		S_DIV_TH   = 15'b000000000100000,
		S_BAM_HI   = 15'b000000001000000,
		S_BAM_LO   = 15'b000000010000000,
		S_GAIN     = 15'b000000100000000,
		S_ROT      = 15'b000001000000000,
		S_MUL_VS   = 15'b000010000000000,
		S_DIV_VS   = 15'b000100000000000,
		S_MUL_VT   = 15'b001000000000000,
		S_DIV_VT   = 15'b010000000000000,
		S_FINISH   = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [15:0] lr_q, rr_q, off_q;
	logic [17:0] tw_q;

	logic        primed_q;
	logic [31:0] last_l_q, last_r_q;
	logic [47:0] last_st_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic [31:0] acc_h_q;

	logic [47:0] dt_q;
	logic signed [31:0] dl_q, dr_q;
	logic signed [32:0] sl_q, sr_q;
	logic signed [50:0] pod_q;
	logic signed [60:0] qoff_q, dth_q, rnum_q;
	logic signed [39:0] dsc_q;
	logic [32:0] bam_hi_q, full_q;
	logic signed [41:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [4:0]  cnt_q;
	logic signed [31:0] vs_q, vt_q;
	logic        div_go_q;
	logic        ov_q;
	logic signed [31:0] ox_q, oy_q, ovs_q, ovt_q;
	logic [31:0] oh_q;

	odo_pkg::div_req_t dreq;
	odo_pkg::div_rsp_t drsp;

	logic signed [33:0] sum, diff;
	logic signed [48:0] pl, pr;
	logic signed [50:0] po;
	logic signed [61:0] ds_full;
	logic [62:0] ph;
	logic [45:0] plo;
	logic [31:0] ang;
	logic signed [64:0] pg;
	logic signed [40:0] x0;
	logic signed [39:0] rmul_a;
	logic signed [61:0] pv;
	logic signed [41:0] xs, ys;
	logic signed [42:0] nx, ny;
	logic [17:0] bdiv;

	assign sum  = {sr_q[32], sr_q} + {sl_q[32], sl_q};
	assign diff = {sr_q[32], sr_q} - {sl_q[32], sl_q};
	assign bdiv = (tw_q == 18'd0) ? 18'd1 : tw_q;

	assign pl = $signed({1'b0, lr_q}) * dl_q;
	assign pr = $signed({1'b0, rr_q}) * dr_q;
	assign po = $signed(off_q) * diff;
	assign ds_full = {{29{sum[33]}}, sum[33:1]} + {qoff_q[60], qoff_q};
	assign ph  = {30'd0, dth_q[48:16]} * {33'd0, odo_pkg::TURN_TO_BAM};
	assign plo = {30'd0, dth_q[15:0]} * {16'd0, odo_pkg::TURN_TO_BAM};
	assign ang = acc_h_q + full_q[32:1];
	assign pg  = dsc_q * $signed({1'b0, odo_pkg::INV_GAIN_Q24});
	assign x0  = pg[64:24];
	// The speed and turn rate numerators share one multiplier input.
	assign rmul_a = (state_q == S_MUL_VS) ? dsc_q : odo_pkg::clamp38(64'(dth_q));
	assign pv  = rmul_a * $signed({1'b0, odo_pkg::USEC_PER_SEC});
	assign xs  = x_q >>> cnt_q;
	assign ys  = y_q >>> cnt_q;
	assign nx  = {{11{acc_x_q[31]}}, acc_x_q} + {x_q[41], x_q};
	assign ny  = {{11{acc_y_q[31]}}, acc_y_q} + {y_q[41], y_q};

	always_comb begin
		dreq.start = div_go_q;
		dreq.num   = rnum_q;
		dreq.den   = {30'd0, bdiv};
		case (state_q)
			S_DIV_OFF: dreq.num = {{10{pod_q[50]}}, pod_q};
			S_DIV_TH:  dreq.num = {{11{diff[33]}}, diff, 16'd0};
			S_DIV_VS, S_DIV_VT: dreq.den = dt_q;
			default: ;
		endcase
	end

	odo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= odo_pkg::LEFT_RADIUS_RST;
			rr_q  <= odo_pkg::RIGHT_RADIUS_RST;
			tw_q  <= odo_pkg::TRACK_WIDTH_RST;
			off_q <= odo_pkg::CENTER_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				odo_pkg::REG_LEFT_RADIUS:   lr_q  <= cfg_data[15:0];
				odo_pkg::REG_RIGHT_RADIUS:  rr_q  <= cfg_data[15:0];
				odo_pkg::REG_TRACK_WIDTH:   tw_q  <= cfg_data;
				odo_pkg::REG_CENTER_OFFSET: off_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			primed_q  <= 1'b0;
			last_l_q  <= '0;
			last_r_q  <= '0;
			last_st_q <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			acc_h_q   <= '0;
			div_go_q  <= 1'b0;
			ov_q      <= 1'b0;
			cnt_q     <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (pose.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						if (!primed_q) begin
							primed_q  <= 1'b1;
							last_l_q  <= sample.left_angle;
							last_r_q  <= sample.right_angle;
							last_st_q <= sample.stamp_us;
						end else if (sample.stamp_us <= last_st_q) begin
							last_st_q <= sample.stamp_us;
						end else begin
							last_l_q  <= sample.left_angle;
							last_r_q  <= sample.right_angle;
							last_st_q <= sample.stamp_us;
							state_q   <= S_MUL_L;
						end
					end
				end
				S_MUL_L:   state_q <= S_MUL_R;
				S_MUL_R:   state_q <= S_MUL_OFF;
				S_MUL_OFF: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_OFF;
				end
				S_DIV_OFF: begin
					if (drsp.done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV_TH;
					end
				end
				S_DIV_TH: begin
					if (drsp.done) begin
						state_q <= S_BAM_HI;
					end
				end
				S_BAM_HI:  state_q <= S_BAM_LO;
				S_BAM_LO:  state_q <= S_GAIN;
				S_GAIN: begin
					cnt_q   <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(NSTEP - 1)) begin
						state_q <= S_MUL_VS;
					end
				end
				S_MUL_VS: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_VS;
				end
				S_DIV_VS: begin
					if (drsp.done) begin
						state_q <= S_MUL_VT;
					end
				end
				S_MUL_VT: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIV_VT;
				end
				S_DIV_VT: begin
					if (drsp.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// Hold the new pose until the previous result has been taken.
					if (!ov_q || pose.ready) begin
						acc_x_q <= odo_pkg::sat32(64'(nx));
						acc_y_q <= odo_pkg::sat32(64'(ny));
						acc_h_q <= acc_h_q + full_q[31:0];
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dt_q <= sample.stamp_us - last_st_q;
				dl_q <= sample.left_angle - last_l_q;
				dr_q <= sample.right_angle - last_r_q;
			end
			S_MUL_L:   sl_q  <= pl[48:16];
			S_MUL_R:   sr_q  <= pr[48:16];
			S_MUL_OFF: pod_q <= po;
			S_DIV_OFF: begin
				if (drsp.done) begin
					qoff_q <= drsp.quo;
				end
			end
			S_DIV_TH: begin
				if (drsp.done) begin
					dth_q <= drsp.quo;
				end
			end
			S_BAM_HI: begin
				bam_hi_q <= ph[32:0];
				dsc_q    <= odo_pkg::clamp38(64'(ds_full));
			end
			S_BAM_LO: full_q <= bam_hi_q + {3'd0, plo[45:16]};
			S_GAIN: begin
				y_q <= '0;
				// Fold the left half plane onto the right one.
				if (ang[31] ^ ang[30]) begin
					x_q <= -{x0[40], x0};
					z_q <= {{2{~ang[31]}}, ~ang[31], ang[30:0]};
				end else begin
					x_q <= {x0[40], x0};
					z_q <= {{2{ang[31]}}, ang};
				end
			end
			S_ROT: begin
				if (!z_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - $signed({2'b00, odo_pkg::ATAN_BAM[cnt_q]});
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + $signed({2'b00, odo_pkg::ATAN_BAM[cnt_q]});
				end
			end
			S_MUL_VS, S_MUL_VT: rnum_q <= pv[60:0];
			S_DIV_VS: begin
				if (drsp.done) begin
					vs_q <= odo_pkg::sat32(64'(drsp.quo));
				end
			end
			S_DIV_VT: begin
				if (drsp.done) begin
					vt_q <= odo_pkg::sat32(64'(drsp.quo));
				end
			end
			S_FINISH: begin
				if (!ov_q || pose.ready) begin
					ox_q  <= odo_pkg::sat32(64'(nx));
					oy_q  <= odo_pkg::sat32(64'(ny));
					oh_q  <= acc_h_q + full_q[31:0];
					ovs_q <= vs_q;
					ovt_q <= vt_q;
				end
			end
			default: ;
		endcase
	end

	assign sample.ready      = (state_q == S_IDLE);
	assign pose.valid        = ov_q;
	assign pose.pose_x       = ox_q;
	assign pose.pose_y       = oy_q;
	assign pose.heading      = oh_q;
	assign pose.linear_speed = ovs_q;
	assign pose.turn_rate    = ovt_q;

endmodule

/* bench/tb_diff_drive_wheel_odometry_core.sv */
// Self-checking testbench for the differential-drive wheel odometry core.
`timescale 1ns / 100ps

module tb_diff_drive_wheel_odometry_core;

	localparam int unsigned CLK_HALF    = 6;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned DRAIN_WAIT  = 400;
	localparam int unsigned NUM_PHASES  = 7;
	localparam int unsigned PHASE_ITEMS = 200;

	typedef struct {
		bit [31:0] pose_x;
		bit [31:0] pose_y;
		bit [31:0] heading;
		bit [31:0] linear_speed;
		bit [31:0] turn_rate;
	} pose_t;

	class odometry_scoreboard;
		bit [15:0]   lrad;
		bit [15:0]   rrad;
		bit [17:0]   trk;
		bit [15:0]   coff;
		bit          primed;
		bit [31:0]   last_la;
		bit [31:0]   last_ra;
		bit [47:0]   last_st;
		int          acc_x;
		int          acc_y;
		bit [31:0]   acc_h;
		pose_t       pending_poses[$];
		int unsigned errors;
		int unsigned n_checked;

		function new();
			lrad = odo_pkg::LEFT_RADIUS_RST;
			rrad = odo_pkg::RIGHT_RADIUS_RST;
			trk = odo_pkg::TRACK_WIDTH_RST;
			coff = odo_pkg::CENTER_OFFSET_RST;
			primed = 0;
			last_la = 0;
			last_ra = 0;
			last_st = 0;
			acc_x = 0;
			acc_y = 0;
			acc_h = 0;
			errors = 0;
			n_checked = 0;
		endfunction

		function void write_reg(odo_pkg::reg_index_t idx, bit [17:0] data);
			case (idx)
				odo_pkg::REG_LEFT_RADIUS: lrad = data[15:0];
				odo_pkg::REG_RIGHT_RADIUS: rrad = data[15:0];
				odo_pkg::REG_TRACK_WIDTH: trk = data;
				odo_pkg::REG_CENTER_OFFSET: coff = data[15:0];
				default: ;
			endcase
		endfunction

		function int sat32(longint v);
			if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return int'(v);
		endfunction

		function longint clamp_travel(longint v);
			longint lim;
			lim = 64'sd274877906944;
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		// Works out the pose that an accepted sample request should produce.
		function void note_sample(bit [31:0] la, bit [31:0] ra, bit [47:0] st);
			longint dl, dr, sl, sr, sum, diff, off, b, ds, dth, x, y, z, xs, ys;
			longint unsigned u, full, dt, turn;
			bit [31:0] ang, half, inc, dla, dra;
			pose_t e;
			if (!primed) begin
				last_la = la;
				last_ra = ra;
				last_st = st;
				primed = 1;
				return;
			end
			if (st <= last_st) begin
				last_st = st;
				return;
			end
			dt = st - last_st;
			dla = la - last_la;
			dra = ra - last_ra;
			dl = $signed(dla);
			dr = $signed(dra);
			last_la = la;
			last_ra = ra;
			last_st = st;
			sl = (longint'(lrad) * dl) >>> 16;
			sr = (longint'(rrad) * dr) >>> 16;
			sum = sr + sl;
			diff = sr - sl;
			off = $signed(coff);
			b = (trk == 0) ? 64'sd1 : longint'(trk);
			ds = (sum >>> 1) + (off * diff) / b;
			dth = (diff * 65536) / b;
			turn = 64'd683565276;
			u = dth;
			full = (u >> 16) * turn + (((u & 64'hFFFF) * turn) >> 16);
			inc = full[31:0];
			half = full[32:1];
			ds = clamp_travel(ds);
			ang = acc_h + half;
			x = (ds * 64'sd10188012) >>> 24;
			y = 0;
			// Rotations beyond a quarter turn start from the opposite vector.
			if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
				ang = ang + 32'h8000_0000;
				x = -x;
			end
			z = $signed(ang);
			for (int i = 0; i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(odo_pkg::ATAN_BAM[i]);
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(odo_pkg::ATAN_BAM[i]);
				end
			end
			acc_x = sat32(longint'(acc_x) + x);
			acc_y = sat32(longint'(acc_y) + y);
			acc_h = acc_h + inc;
			e.pose_x = acc_x;
			e.pose_y = acc_y;
			e.heading = acc_h;
			e.linear_speed = sat32((ds * 64'sd1000000) / longint'(dt));
			e.turn_rate = sat32((clamp_travel(dth) * 64'sd1000000) / longint'(dt));
			pending_poses.push_back(e);
		endfunction

		task report(string what, bit [31:0] got, bit [31:0] want);
			errors++;
			$display("MISMATCH pose %0d %s: got %h expected %h", n_checked, what, got, want);
		endtask

		task check_pose(pose_t got);
			pose_t want;
			if (pending_poses.size() == 0) begin
				report("unexpected result pose_x", got.pose_x, 32'h0);
			end else begin
				want = pending_poses.pop_front();
				if (got.pose_x != want.pose_x) report("pose_x", got.pose_x, want.pose_x);
				if (got.pose_y != want.pose_y) report("pose_y", got.pose_y, want.pose_y);
				if (got.heading != want.heading) report("heading", got.heading, want.heading);
				if (got.linear_speed != want.linear_speed)
					report("linear_speed", got.linear_speed, want.linear_speed);
				if (got.turn_rate != want.turn_rate)
					report("turn_rate", got.turn_rate, want.turn_rate);
			end
			n_checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [17:0] cfg_data;

	odo_in_if  sample();
	odo_out_if pose();

	diff_drive_wheel_odometry_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.pose      (pose)
	);

	odometry_scoreboard sb;
	int unsigned cycles;
	int unsigned n_sent;
	bit          no_idle;
	bit [31:0]   cur_la;
	bit [31:0]   cur_ra;
	bit [47:0]   cur_st;

	always begin
		clk = 1'b1;
		#(CLK_HALF);
		clk = 1'b0;
		#(CLK_HALF);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task send_sample(bit [31:0] la, bit [31:0] ra, bit [47:0] st);
		int unsigned gap;
		@(negedge clk);
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample.valid <= 1'b1;
		sample.left_angle <= la;
		sample.right_angle <= ra;
		sample.stamp_us <= st;
		do @(posedge clk); while (!sample.ready);
		sb.note_sample(la, ra, st);
		cur_la = la;
		cur_ra = ra;
		cur_st = st;
		n_sent++;
	endtask

	// Holds the sender back until every pose owed has come out.
	task drain();
		@(negedge clk);
		sample.valid <= 1'b0;
		while (sb.pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task write_reg(odo_pkg::reg_index_t idx, bit [17:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task set_geometry(bit [15:0] l, bit [15:0] r, bit [17:0] t, bit [15:0] c);
		write_reg(odo_pkg::REG_LEFT_RADIUS, {2'b0, l});
		write_reg(odo_pkg::REG_RIGHT_RADIUS, {2'b0, r});
		write_reg(odo_pkg::REG_TRACK_WIDTH, t);
		write_reg(odo_pkg::REG_CENTER_OFFSET, {2'b0, c});
	endtask

	task send_random();
		int unsigned kind;
		bit [31:0] la, ra, dl, dr;
		bit [47:0] st;
		kind = $urandom_range(0, 99);
		if (kind < 4) begin
			dl = $urandom();
			dr = $urandom();
		end else if (kind < 30) begin
			dl = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			dr = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
		end else begin
			dl = $urandom_range(0, 32'h3FFF) - 32'h2000;
			dr = dl + $urandom_range(0, 32'h7FF) - 32'h400;
		end
		la = cur_la + dl;
		ra = cur_ra + dr;
		if (kind >= 92) begin
			st = cur_st - 48'($urandom_range(0, 3));
		end else if (kind >= 90) begin
			st = {16'($urandom()), $urandom()};
		end else if (kind >= 86) begin
			st = cur_st + 48'($urandom_range(1, 3));
		end else if (kind >= 84) begin
			st = cur_st + {16'($urandom_range(0, 65535)), $urandom()};
		end else begin
			st = cur_st + 48'($urandom_range(1, 20000));
		end
		send_sample(la, ra, st);
	endtask

	initial begin
		pose_t got;
		int unsigned w;
		pose.ready = 1'b0;
		forever begin
			@(negedge clk);
			w = no_idle ? 0 : $urandom_range(0, 5);
			if (w > 0) begin
				pose.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			pose.ready <= 1'b1;
			do @(posedge clk); while (!(pose.valid && pose.ready));
			got.pose_x = pose.pose_x;
			got.pose_y = pose.pose_y;
			got.heading = pose.heading;
			got.linear_speed = pose.linear_speed;
			got.turn_rate = pose.turn_rate;
			sb.check_pose(got);
		end
	end

	initial begin
		sb = new();
		cycles = 0;
		n_sent = 0;
		no_idle = 0;
		cur_la = 0;
		cur_ra = 0;
		cur_st = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = odo_pkg::REG_LEFT_RADIUS;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.left_angle = '0;
		sample.right_angle = '0;
		sample.stamp_us = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset geometry.
		send_sample(32'h0000_1000, 32'hFFFF_F000, 48'd100);
		send_sample(32'h0000_1000, 32'hFFFF_F000, 48'd1100);
		send_sample(32'h0001_0000, 32'h0002_0000, 48'd2100);
		send_sample(32'h0001_0000, 32'h0002_0000, 48'd2100);
		send_sample(32'h0003_0000, 32'h0001_0000, 48'd50);
		send_sample(32'h0004_0000, 32'h0000_0000, 48'd51);
		send_sample(32'h8004_0000, 32'h8000_0000, 48'd52);
		send_sample(32'h0004_0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFE);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 48'h0);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000, 48'h1);
		send_sample(32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555);
		send_sample(32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: ;
				1: set_geometry(16'hFFFF, 16'hFFFF, 18'd1, 16'h7FFF);
				2: set_geometry(16'd1, 16'd1, 18'h3FFFF, 16'h8000);
				3: set_geometry(16'd30000, 16'd2000, 18'd0, 16'hFC18);
				default: set_geometry(16'($urandom_range(1, 65535)),
					16'($urandom_range(1, 65535)), 18'($urandom_range(1, 262143)),
					16'($urandom_range(0, 65535)));
			endcase
			no_idle = (p == 4);
			for (int k = 0; k < PHASE_ITEMS; k++) send_random();
			drain();
		end
		no_idle = 0;
		drain();

		$display("Sent %0d sample requests over %0d geometry settings; %0d poses checked.",
			n_sent, NUM_PHASES, sb.n_checked);
		if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d poses missing", sb.errors,
				sb.pending_poses.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
